>>> src/majority_vote_mode_debouncer_macros.svh
// Assertion macros shared by the debouncer modules.
`ifndef MAJORITY_VOTE_MODE_DEBOUNCER_MACROS_SVH
`define MAJORITY_VOTE_MODE_DEBOUNCER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MVMD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mvmd assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MVMD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mvmd assertion failed");

`endif

>>> src/mvmd_pkg.sv
// Types and constants shared by the mode debouncer modules.
`default_nettype none
package mvmd_pkg;

    localparam int MODE_W     = 3;
    localparam int TIME_W     = 48;
    localparam int THRESH_W   = 3;
    localparam int HOLD_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 1'd1;

    localparam logic [MODE_W-1:0]   MODE_UNKNOWN    = 3'd0;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 3'd4;
    localparam logic [HOLD_W-1:0]   HOLD_RESET      = 32'd10000;

    typedef struct packed {
        logic              majority;
        logic [MODE_W-1:0] winner;
    } vote_t;

    typedef struct packed {
        logic [MODE_W-1:0] confirmed_mode;
        logic [MODE_W-1:0] majority_mode;
        logic              pending_flag;
        logic              switch_confirmed;
        logic [MODE_W-1:0] ended_mode;
        logic [TIME_W-1:0] segment_begin_ms;
        logic [TIME_W-1:0] segment_length_ms;
    } result_t;

endpackage
`default_nettype wire

>>> src/majority_vote_mode_debouncer.sv
// Mode debouncer top level: input register, window vote, stable tracking, result register.
// One sample word is taken per clock while sample_stall is low. The sample sits in an
// input register, then the window update, the majority search over the per-mode tallies
// and the 48-bit hold-time compare all run combinationally into the result register.
// While a result waits on result_stall the input register still takes one more sample;
// sample_stall rises only when both registers are full. A timestamp lower than the
// previous nonzero one resets the tracking state but not the configuration.
`default_nettype none
`include "majority_vote_mode_debouncer_macros.svh"
module majority_vote_mode_debouncer #(
    parameter int WINDOW_DEPTH = 5,
    parameter int MODE_COUNT   = 7
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [mvmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [mvmd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                 sample_valid,
    output logic                                sample_stall,
    input  wire  [mvmd_pkg::MODE_W-1:0]         mode_code,
    input  wire  [mvmd_pkg::TIME_W-1:0]         time_ms,
    output logic                                result_valid,
    input  wire                                 result_stall,
    output logic [mvmd_pkg::MODE_W-1:0]         confirmed_mode,
    output logic [mvmd_pkg::MODE_W-1:0]         majority_mode,
    output logic                                pending_flag,
    output logic                                switch_confirmed,
    output logic [mvmd_pkg::MODE_W-1:0]         ended_mode,
    output logic [mvmd_pkg::TIME_W-1:0]         segment_begin_ms,
    output logic [mvmd_pkg::TIME_W-1:0]         segment_length_ms
);

    logic [mvmd_pkg::THRESH_W-1:0] threshold_reg;
    logic [mvmd_pkg::HOLD_W-1:0]   hold_reg;

    logic                          in_valid_reg;
    logic [mvmd_pkg::MODE_W-1:0]   mode_reg;
    logic [mvmd_pkg::TIME_W-1:0]   time_reg;
    logic                          out_valid_reg;
    mvmd_pkg::result_t             result_reg;

    logic                          advance;
    logic                          fire;
    logic                          accept;
    logic                          clear;
    logic [mvmd_pkg::MODE_W-1:0]   mode_norm;
    mvmd_pkg::vote_t               vote;
    mvmd_pkg::result_t             result;

    assign advance      = !out_valid_reg || !result_stall;
    assign fire         = in_valid_reg && advance;
    assign sample_stall = in_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    // codes at or above the mode count count as unknown
    assign mode_norm = (int'(mode_reg) >= MODE_COUNT) ? mvmd_pkg::MODE_UNKNOWN : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= mvmd_pkg::THRESHOLD_RESET;
            hold_reg      <= mvmd_pkg::HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mvmd_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[mvmd_pkg::THRESH_W-1:0];
                mvmd_pkg::REG_HOLD:      hold_reg      <= cfg_data[mvmd_pkg::HOLD_W-1:0];
                default:                 hold_reg      <= hold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode_code;
            time_reg <= time_ms;
        end
        if (fire)
        begin
            result_reg <= result;
        end
    end

    mvmd_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MODE_COUNT   (MODE_COUNT)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .clear     (clear),
        .mode      (mode_norm),
        .threshold (threshold_reg),
        .vote      (vote)
    );

    mvmd_tracker u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .time_ms      (time_reg),
        .vote         (vote),
        .hold_time_ms (hold_reg),
        .clear        (clear),
        .result       (result)
    );

    assign result_valid      = out_valid_reg;
    assign confirmed_mode    = result_reg.confirmed_mode;
    assign majority_mode     = result_reg.majority_mode;
    assign pending_flag      = result_reg.pending_flag;
    assign switch_confirmed  = result_reg.switch_confirmed;
    assign ended_mode        = result_reg.ended_mode;
    assign segment_begin_ms  = result_reg.segment_begin_ms;
    assign segment_length_ms = result_reg.segment_length_ms;

    `MVMD_ASSERT_NEXT(a_fire_gives_result, fire, result_valid)
    `MVMD_ASSERT_IMPL(a_switch_report, result_valid && switch_confirmed,
        (confirmed_mode != ended_mode) && !pending_flag
        && (ended_mode != mvmd_pkg::MODE_UNKNOWN))
    `MVMD_ASSERT_IMPL(a_quiet_report, result_valid && !switch_confirmed,
        (ended_mode == mvmd_pkg::MODE_UNKNOWN) && (segment_begin_ms == '0)
        && (segment_length_ms == '0))

endmodule
`default_nettype wire

>>> src/mvmd_window.sv
// Sliding window of recent modes with per-mode tallies and the majority vote.
`default_nettype none
module mvmd_window #(
    parameter int WINDOW_DEPTH = 5,
    parameter int MODE_COUNT   = 7
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              fire,
    input  wire                              clear,
    input  wire  [mvmd_pkg::MODE_W-1:0]      mode,
    input  wire  [mvmd_pkg::THRESH_W-1:0]    threshold,
    output mvmd_pkg::vote_t                  vote
);

    localparam int TW = $clog2(WINDOW_DEPTH + 1);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = $clog2(WINDOW_DEPTH);
    localparam int CW = (TW > mvmd_pkg::THRESH_W) ? TW : mvmd_pkg::THRESH_W;

    logic [mvmd_pkg::MODE_W-1:0] win_reg [WINDOW_DEPTH];
    logic [TW-1:0]               tally_reg [MODE_COUNT];
    logic [TW-1:0]               tally_eff [MODE_COUNT];
    logic [TW-1:0]               tally_next [MODE_COUNT];
    logic [FW-1:0]               fill_reg;
    logic [FW-1:0]               fill_eff;
    logic [FW-1:0]               fill_next;
    logic [SW-1:0]               slot_reg;
    logic [SW-1:0]               slot_eff;
    logic [SW-1:0]               slot_next;
    logic [mvmd_pkg::MODE_W-1:0] old_mode;
    logic                        full;

    always_comb
    begin
        fill_eff  = clear ? '0 : fill_reg;
        slot_eff  = clear ? '0 : slot_reg;
        full      = (fill_eff == FW'(WINDOW_DEPTH));
        fill_next = full ? fill_eff : fill_eff + FW'(1);
        slot_next = (slot_eff == SW'(WINDOW_DEPTH - 1)) ? '0 : slot_eff + SW'(1);
        old_mode  = clear ? mvmd_pkg::MODE_UNKNOWN : win_reg[slot_eff];
        for (int k = 0; k < MODE_COUNT; k++)
        begin
            tally_eff[k]  = clear ? '0 : tally_reg[k];
            tally_next[k] = tally_eff[k];
            // drop the word leaving a full window, count the new one
            if (full && (int'(old_mode) == k) && (tally_eff[k] != '0))
            begin
                tally_next[k] = tally_next[k] - TW'(1);
            end
            if (int'(mode) == k)
            begin
                tally_next[k] = tally_next[k] + TW'(1);
            end
        end
    end

    // lowest code reaching the threshold wins
    always_comb
    begin
        vote.majority = 1'b0;
        vote.winner   = mvmd_pkg::MODE_UNKNOWN;
        for (int k = MODE_COUNT - 1; k >= 0; k--)
        begin
            if (CW'(tally_next[k]) >= CW'(threshold))
            begin
                vote.majority = 1'b1;
                vote.winner   = mvmd_pkg::MODE_W'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            slot_reg <= '0;
            for (int k = 0; k < MODE_COUNT; k++)
            begin
                tally_reg[k] <= '0;
            end
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                win_reg[i] <= mvmd_pkg::MODE_UNKNOWN;
            end
        end
        else if (fire)
        begin
            fill_reg <= fill_next;
            slot_reg <= slot_next;
            for (int k = 0; k < MODE_COUNT; k++)
            begin
                tally_reg[k] <= tally_next[k];
            end
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                if (SW'(i) == slot_eff)
                begin
                    win_reg[i] <= mode;
                end
                else if (clear)
                begin
                    win_reg[i] <= mvmd_pkg::MODE_UNKNOWN;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> src/mvmd_tracker.sv
// Stable mode tracking: first adoption, pending hold timer, switch and segment report.
`default_nettype none
`include "majority_vote_mode_debouncer_macros.svh"
module mvmd_tracker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             fire,
    input  wire  [mvmd_pkg::TIME_W-1:0]     time_ms,
    input  mvmd_pkg::vote_t                 vote,
    input  wire  [mvmd_pkg::HOLD_W-1:0]     hold_time_ms,
    output logic                            clear,
    output mvmd_pkg::result_t               result
);

    localparam int TW = mvmd_pkg::TIME_W;
    localparam int MW = mvmd_pkg::MODE_W;

    logic [TW-1:0] last_time_reg;
    logic [MW-1:0] instant_reg;
    logic [MW-1:0] instant_next;
    logic [MW-1:0] stable_reg;
    logic [MW-1:0] stable_next;
    logic [MW-1:0] target_reg;
    logic [MW-1:0] target_next;
    logic          pending_reg;
    logic          pending_next;
    logic [TW-1:0] since_reg;
    logic [TW-1:0] since_next;
    logic [TW-1:0] seg_start_reg;
    logic [TW-1:0] seg_start_next;

    logic [MW-1:0] stable_eff;
    logic [MW-1:0] target_eff;
    logic          pending_eff;
    logic [TW-1:0] since_eff;
    logic [TW-1:0] seg_start_eff;
    logic [TW-1:0] held_ms;
    logic          hold_done;

    // a backward timestamp wipes the tracking state before this word
    assign clear = (last_time_reg != '0) && (time_ms < last_time_reg);

    always_comb
    begin
        stable_eff    = clear ? mvmd_pkg::MODE_UNKNOWN : stable_reg;
        target_eff    = clear ? mvmd_pkg::MODE_UNKNOWN : target_reg;
        pending_eff   = clear ? 1'b0 : pending_reg;
        since_eff     = clear ? '0 : since_reg;
        seg_start_eff = clear ? '0 : seg_start_reg;

        instant_next = vote.majority ? vote.winner
                     : (clear ? mvmd_pkg::MODE_UNKNOWN : instant_reg);

        held_ms   = time_ms - since_eff;
        hold_done = (time_ms >= since_eff) && (held_ms >= TW'(hold_time_ms));

        stable_next    = stable_eff;
        target_next    = target_eff;
        pending_next   = pending_eff;
        since_next     = since_eff;
        seg_start_next = seg_start_eff;

        result.switch_confirmed  = 1'b0;
        result.ended_mode        = mvmd_pkg::MODE_UNKNOWN;
        result.segment_begin_ms  = '0;
        result.segment_length_ms = '0;

        if (stable_eff == mvmd_pkg::MODE_UNKNOWN)
        begin
            if ((instant_next != mvmd_pkg::MODE_UNKNOWN) && vote.majority)
            begin
                stable_next    = instant_next;
                seg_start_next = time_ms;
                pending_next   = 1'b0;
            end
        end
        else if (instant_next != mvmd_pkg::MODE_UNKNOWN)
        begin
            if (instant_next == stable_eff)
            begin
                pending_next = 1'b0;
            end
            else if (!pending_eff || (target_eff != instant_next))
            begin
                // arm the hold timer for a new candidate
                pending_next = 1'b1;
                target_next  = instant_next;
                since_next   = time_ms;
            end
            else if (hold_done)
            begin
                result.switch_confirmed  = 1'b1;
                result.ended_mode        = stable_eff;
                result.segment_begin_ms  = seg_start_eff;
                result.segment_length_ms = (time_ms >= seg_start_eff)
                                         ? time_ms - seg_start_eff : '0;
                stable_next    = instant_next;
                seg_start_next = time_ms;
                pending_next   = 1'b0;
            end
        end

        result.confirmed_mode = stable_next;
        result.majority_mode  = instant_next;
        result.pending_flag   = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            instant_reg   <= mvmd_pkg::MODE_UNKNOWN;
            stable_reg    <= mvmd_pkg::MODE_UNKNOWN;
            target_reg    <= mvmd_pkg::MODE_UNKNOWN;
            pending_reg   <= 1'b0;
            since_reg     <= '0;
            seg_start_reg <= '0;
        end
        else if (fire)
        begin
            last_time_reg <= time_ms;
            instant_reg   <= instant_next;
            stable_reg    <= stable_next;
            target_reg    <= target_next;
            pending_reg   <= pending_next;
            since_reg     <= since_next;
            seg_start_reg <= seg_start_next;
        end
    end

    `MVMD_ASSERT_IMPL(a_pending_needs_stable, pending_reg, stable_reg != mvmd_pkg::MODE_UNKNOWN)
    `MVMD_ASSERT_IMPL(a_pending_differs, pending_reg && !clear, target_reg != stable_reg)
    `MVMD_ASSERT_NEXT(a_time_tracked, fire, last_time_reg == $past(time_ms))

endmodule
`default_nettype wire
